FILE: src/pcv_pkg.sv
`default_nettype none

package pcv_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 256;
  localparam int unsigned HDR_BYTES            = 8;
  localparam int unsigned MIN_PACKET_BYTES     = 10;
  localparam int unsigned QUEUE_DEPTH          = 4;
  localparam logic [15:0] SUM_MASK             = 16'hffff;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HDR_BAD  = 2'd1,
    ST_LEN_BAD  = 2'd2,
    ST_BODY_BAD = 2'd3
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    HW_COMMAND = 2'd0,
    HW_SIZE    = 2'd1,
    HW_RESULT  = 2'd2,
    HW_CHECK   = 2'd3
  } hdr_word_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_packet;
  } in_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [15:0] command_code;
    logic [15:0] result_code;
    logic [7:0]  payload_length;
    logic        is_last;
  } out_t;

  // One queue entry: at most a payload byte and a status for one input byte.
  typedef struct packed {
    logic        has_pay;
    logic [7:0]  pay_byte;
    logic        pay_hi;
    logic        has_stat;
    status_t     stat_pre;
    logic        body_chk;
    logic [15:0] footer;
    logic [15:0] command;
    logic [15:0] result;
    logic [7:0]  plen;
  } qent_t;

  // Inverted ones' complement fold of an 18-bit sum.
  function automatic logic [15:0] inv_fold18(input logic [17:0] s);
    logic [16:0] f1;
    logic [15:0] f2;
    f1 = 17'(s[15:0]) + 17'(s[17:16]);
    f2 = f1[15:0] + 16'(f1[16]);
    return (~f2) & SUM_MASK;
  endfunction

endpackage

`default_nettype wire

FILE: src/packet_checksum_verifier.sv
`default_nettype none

// Packet checker: takes one received byte per request and, once the packet
// ends, reports a status with the header command and result words. Payload
// bytes come out two bytes after they arrive, so the 2-byte footer is never
// forwarded; discard the payload when the status is not ok. The front end
// accepts one byte every cycle while the 4-entry queue has room. The output
// register gives one result per cycle while out_ready is high, so a byte that
// both releases a payload byte and ends the packet yields two results; queue
// depth absorbs that. Bytes past MAX_PACKET_BYTES are dropped and flagged as a
// length error, as is any packet shorter than 10 bytes.
module packet_checksum_verifier #(
  parameter int unsigned MAX_PACKET_BYTES = pcv_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pcv_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pcv_pkg::out_t      out_data
);

  pcv_pkg::qent_t push_ent;
  pcv_pkg::qent_t head_ent;
  logic           push;
  logic           pop;
  logic           head_vld;
  logic           full;
  logic           acc;

  assign in_ready = !full;
  assign acc      = in_valid && in_ready;

  pcv_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_data  (in_data),
    .push_ent (push_ent),
    .push     (push)
  );

  pcv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head_ent (head_ent),
    .head_vld (head_vld),
    .full     (full)
  );

  pcv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_ent  (head_ent),
    .head_vld  (head_vld),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: src/pcv_front.sv
`default_nettype none

module pcv_front #(
  parameter int unsigned MAX_PACKET_BYTES = pcv_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         acc,
  input  wire pcv_pkg::in_t in_data,
  output pcv_pkg::qent_t    push_ent,
  output logic              push
);

  localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 2);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PACKET_BYTES);
  localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(MAX_PACKET_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_HDR  = CNT_W'(pcv_pkg::HDR_BYTES);
  localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(pcv_pkg::MIN_PACKET_BYTES);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      cmd_r, cmd_nxt;
  logic [15:0]      size_r, size_nxt;
  logic [15:0]      res_r, res_nxt;
  logic [15:0]      chk_r, chk_nxt;
  logic [7:0]       dly0_r, dly0_nxt;
  logic [7:0]       dly1_r, dly1_nxt;

  logic             in_range;
  logic             is_hdr;
  logic             is_pay;
  logic [CNT_W-1:0] n_sat;
  logic [15:0]      hdr_calc;
  logic             len_bad;

  assign in_range = cnt_r < CNT_MAX;
  assign is_hdr   = in_range && (cnt_r < CNT_HDR);
  assign is_pay   = in_range && (cnt_r >= CNT_MIN);
  assign cnt_nxt  = (cnt_r < CNT_SAT) ? cnt_r + CNT_W'(1) : cnt_r;

  always_comb begin
    cmd_nxt  = cmd_r;
    size_nxt = size_r;
    res_nxt  = res_r;
    chk_nxt  = chk_r;
    dly0_nxt = dly0_r;
    dly1_nxt = dly1_r;
    if (is_hdr) begin
      unique case (pcv_pkg::hdr_word_t'(cnt_r[2:1]))
        pcv_pkg::HW_COMMAND: begin
          if (cnt_r[0]) cmd_nxt[15:8] = in_data.rx_byte;
          else          cmd_nxt[7:0]  = in_data.rx_byte;
        end
        pcv_pkg::HW_SIZE: begin
          if (cnt_r[0]) size_nxt[15:8] = in_data.rx_byte;
          else          size_nxt[7:0]  = in_data.rx_byte;
        end
        pcv_pkg::HW_RESULT: begin
          if (cnt_r[0]) res_nxt[15:8] = in_data.rx_byte;
          else          res_nxt[7:0]  = in_data.rx_byte;
        end
        pcv_pkg::HW_CHECK: begin
          if (cnt_r[0]) chk_nxt[15:8] = in_data.rx_byte;
          else          chk_nxt[7:0]  = in_data.rx_byte;
        end
        default: ;
      endcase
    end else if (in_range) begin
      // advance the two-byte delay line that holds back the footer
      dly0_nxt = dly1_r;
      dly1_nxt = in_data.rx_byte;
    end
  end

  assign n_sat    = (cnt_nxt > CNT_MAX) ? CNT_MAX : cnt_nxt;
  assign hdr_calc = pcv_pkg::inv_fold18(18'(cmd_nxt) + 18'(size_nxt) + 18'(res_nxt));
  assign len_bad  = (cnt_nxt < CNT_MIN) || (cnt_nxt > CNT_MAX);

  always_comb begin
    push_ent          = '0;
    push_ent.has_pay  = is_pay;
    push_ent.pay_byte = dly0_r;
    push_ent.pay_hi   = cnt_r[0];
    push_ent.has_stat = in_data.end_of_packet;
    push_ent.footer   = {dly1_nxt, dly0_nxt};
    push_ent.command  = cmd_nxt;
    push_ent.result   = res_nxt;
    push_ent.plen     = len_bad && (cnt_nxt < CNT_MIN) ? 8'd0 : 8'(n_sat - CNT_MIN);
    priority if (len_bad) begin
      push_ent.stat_pre = pcv_pkg::ST_LEN_BAD;
    end else if (hdr_calc != chk_nxt) begin
      push_ent.stat_pre = pcv_pkg::ST_HDR_BAD;
    end else if (size_nxt != 16'(cnt_nxt)) begin
      push_ent.stat_pre = pcv_pkg::ST_LEN_BAD;
    end else begin
      push_ent.stat_pre = pcv_pkg::ST_OK;
      push_ent.body_chk = 1'b1;
    end
  end

  assign push = acc && (is_pay || in_data.end_of_packet);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      cmd_r  <= '0;
      size_r <= '0;
      res_r  <= '0;
      chk_r  <= '0;
      dly0_r <= '0;
      dly1_r <= '0;
    end else if (acc) begin
      if (in_data.end_of_packet) begin
        cnt_r  <= '0;
        cmd_r  <= '0;
        size_r <= '0;
        res_r  <= '0;
        chk_r  <= '0;
        dly0_r <= '0;
        dly1_r <= '0;
      end else begin
        cnt_r  <= cnt_nxt;
        cmd_r  <= cmd_nxt;
        size_r <= size_nxt;
        res_r  <= res_nxt;
        chk_r  <= chk_nxt;
        dly0_r <= dly0_nxt;
        dly1_r <= dly1_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/pcv_queue.sv
`default_nettype none

module pcv_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire pcv_pkg::qent_t push_ent,
  input  wire logic           pop,
  output pcv_pkg::qent_t      head_ent,
  output logic                head_vld,
  output logic                full
);

  localparam int unsigned PTR_W = $clog2(pcv_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(pcv_pkg::QUEUE_DEPTH + 1);

  pcv_pkg::qent_t   ent_r [pcv_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;

  assign head_ent = ent_r[rp_r];
  assign head_vld = cnt_r != '0;
  assign full     = cnt_r == CNT_W'(pcv_pkg::QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PTR_W'(1);
      if (pop)  rp_r <= rp_r + PTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

FILE: src/pcv_back.sv
`default_nettype none

module pcv_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire pcv_pkg::qent_t head_ent,
  input  wire logic           head_vld,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output pcv_pkg::out_t       out_data
);

  logic           stat_phase_r;
  logic [15:0]    sum_r;
  logic           out_valid_r;
  pcv_pkg::out_t  out_data_r;

  logic           load;
  logic           emit_pay;
  logic [16:0]    sum_raw;
  logic [15:0]    sum_nxt;
  pcv_pkg::out_t  item;

  assign load     = head_vld && (!out_valid_r || out_ready);
  assign emit_pay = head_ent.has_pay && !stat_phase_r;
  assign pop      = load && !(emit_pay && head_ent.has_stat);

  // add the byte in its lane, wrap the carry back in
  assign sum_raw = 17'(sum_r) + (head_ent.pay_hi ? {1'b0, head_ent.pay_byte, 8'h00}
                                                 : {9'h000, head_ent.pay_byte});
  assign sum_nxt = sum_raw[15:0] + 16'(sum_raw[16]);

  always_comb begin
    item = '0;
    if (emit_pay) begin
      item.item_kind    = pcv_pkg::KIND_PAYLOAD;
      item.payload_byte = head_ent.pay_byte;
      item.is_last      = !head_ent.has_stat;
    end else begin
      item.item_kind      = pcv_pkg::KIND_STATUS;
      item.command_code   = head_ent.command;
      item.result_code    = head_ent.result;
      item.payload_length = head_ent.plen;
      item.is_last        = 1'b1;
      if (head_ent.body_chk)
        item.status = ((~sum_r & pcv_pkg::SUM_MASK) != head_ent.footer) ?
                      pcv_pkg::ST_BODY_BAD : pcv_pkg::ST_OK;
      else
        item.status = head_ent.stat_pre;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      stat_phase_r <= 1'b0;
      sum_r        <= '0;
    end else begin
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (load) begin
        if (emit_pay) begin
          sum_r        <= sum_nxt;
          stat_phase_r <= head_ent.has_stat;
        end else begin
          // status sent: start the next packet from a clean sum
          sum_r        <= '0;
          stat_phase_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: dv/packet_checksum_verifier_test.sv
`timescale 1ns / 1ps

module packet_checksum_verifier_test;

  localparam int unsigned MAX_BYTES     = pcv_pkg::MAX_PACKET_BYTES_DEF;
  localparam int unsigned RANDOM_BYTES  = 160;
  localparam int unsigned CALM_BYTES    = 50;
  localparam int unsigned LONG_HOLD     = 48;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef enum logic [1:0] {
    FILL_ZERO,
    FILL_ONES,
    FILL_RANDOM,
    FILL_NOISE
  } fill_t;

  // One packet of stimulus; nonzero flips corrupt the size, header check or footer.
  typedef struct packed {
    logic [8:0]        nbytes;
    logic [15:0]       cmd;
    logic [15:0]       res;
    fill_t             fill;
    logic [15:0]       size_flip;
    logic [15:0]       chk_flip;
    logic [15:0]       foot_flip;
    logic              st_known;
    pcv_pkg::status_t  st;
    logic [7:0]        plen;
  } pkt_row_t;

  localparam int N_DIRECTED = 16;
  localparam pkt_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{9'd10,  16'h0000, 16'h0000, FILL_ZERO,   16'h0000, 16'h0000, 16'h0000, 1'b1,
      pcv_pkg::ST_OK, 8'd0},
    '{9'd1,   16'h1234, 16'h5678, FILL_ZERO,   16'h0000, 16'h0000, 16'h0000, 1'b1,
      pcv_pkg::ST_LEN_BAD, 8'd0},
    '{9'd9,   16'hffff, 16'hffff, FILL_ONES,   16'h0000, 16'h0000, 16'h0000, 1'b1,
      pcv_pkg::ST_LEN_BAD, 8'd0},
    '{9'd11,  16'hffff, 16'hffff, FILL_ONES,   16'h0000, 16'h0000, 16'h0000, 1'b1,
      pcv_pkg::ST_OK, 8'd1},
    '{9'd12,  16'ha55a, 16'h0001, FILL_RANDOM, 16'h0000, 16'h0000, 16'h0000, 1'b0,
      pcv_pkg::ST_OK, 8'd0},
    '{9'd14,  16'h0003, 16'h0000, FILL_ZERO,   16'h0000, 16'h0001, 16'h0000, 1'b1,
      pcv_pkg::ST_HDR_BAD, 8'd4},
    '{9'd14,  16'h0003, 16'h0000, FILL_ZERO,   16'h0100, 16'h0000, 16'h0000, 1'b1,
      pcv_pkg::ST_LEN_BAD, 8'd4},
    '{9'd15,  16'h0007, 16'h00ff, FILL_ONES,   16'h0000, 16'h0000, 16'h8000, 1'b1,
      pcv_pkg::ST_BODY_BAD, 8'd5},
    '{9'd16,  16'h0002, 16'h0000, FILL_RANDOM, 16'h0001, 16'hffff, 16'h0000, 1'b1,
      pcv_pkg::ST_HDR_BAD, 8'd6},
    '{9'd16,  16'h0002, 16'h0000, FILL_RANDOM, 16'h0002, 16'h0000, 16'h0001, 1'b1,
      pcv_pkg::ST_LEN_BAD, 8'd6},
    '{9'd8,   16'h0009, 16'h0000, FILL_ZERO,   16'h0000, 16'h00ff, 16'h0000, 1'b1,
      pcv_pkg::ST_LEN_BAD, 8'd0},
    '{9'd258, 16'h0011, 16'h0000, FILL_ONES,   16'h0000, 16'h0000, 16'h0000, 1'b1,
      pcv_pkg::ST_LEN_BAD, 8'd246},
    '{9'd20,  16'h0000, 16'hffff, FILL_ZERO,   16'h0000, 16'h0000, 16'h0000, 1'b1,
      pcv_pkg::ST_OK, 8'd10},
    '{9'd17,  16'h8001, 16'h7ffe, FILL_RANDOM, 16'h0000, 16'h0000, 16'h0000, 1'b0,
      pcv_pkg::ST_OK, 8'd0},
    '{9'd30,  16'hfffe, 16'h0000, FILL_ONES,   16'h0000, 16'h0000, 16'h0100, 1'b1,
      pcv_pkg::ST_BODY_BAD, 8'd20},
    '{9'd13,  16'h0000, 16'h0000, FILL_NOISE,  16'h0000, 16'h0000, 16'h0000, 1'b0,
      pcv_pkg::ST_OK, 8'd0}
  };

  logic          clk;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  pcv_pkg::in_t  in_data   = '0;
  logic          out_ready = 1'b0;
  logic          in_ready;
  logic          out_valid;
  pcv_pkg::out_t out_data;

  // Checker state: a copy of the packet tracker inside the block.
  logic [8:0]  seen_bytes;
  logic [15:0] hdr_words [4];
  logic [15:0] body_total;
  logic [7:0]  trail_bytes [2];

  pcv_pkg::out_t due_results [$];
  int unsigned   error_count = 0;
  int unsigned   bytes_sent  = 0;
  bit            calm        = 1'b0;
  bit            hold_req    = 1'b0;

  packet_checksum_verifier i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("packet_checksum_verifier_test: errors");
    $finish;
  end

  function automatic logic [15:0] fold_invert(input logic [31:0] s);
    logic [31:0] c;
    c = (s >> 16) + (s & 32'h0000_ffff);
    c = c + (c >> 16);
    return ~c[15:0];
  endfunction

  function automatic void clear_tracker();
    seen_bytes = '0;
    foreach (hdr_words[w]) hdr_words[w] = '0;
    body_total     = '0;
    trail_bytes[0] = '0;
    trail_bytes[1] = '0;
  endfunction

  function automatic void predict_byte(input pcv_pkg::in_t d);
    pcv_pkg::out_t    pay_item;
    pcv_pkg::out_t    stat_item;
    bit               has_pay;
    bit               has_stat;
    logic [16:0]      acc;
    int unsigned      n;
    int unsigned      kept;
    pcv_pkg::status_t verdict;
    pay_item  = '0;
    stat_item = '0;
    has_pay   = 1'b0;
    has_stat  = 1'b0;
    if (seen_bytes < MAX_BYTES) begin
      if (seen_bytes < pcv_pkg::HDR_BYTES) begin
        if (seen_bytes[0]) begin
          hdr_words[seen_bytes[2:1]][15:8] = d.rx_byte;
        end else begin
          hdr_words[seen_bytes[2:1]][7:0] = d.rx_byte;
        end
      end else begin
        // Release the byte seen two requests ago; odd payload offsets are high bytes.
        if (seen_bytes >= pcv_pkg::MIN_PACKET_BYTES) begin
          acc = 17'(body_total) +
                (seen_bytes[0] ? {1'b0, trail_bytes[0], 8'h00} : 17'(trail_bytes[0]));
          body_total = acc[15:0] + 16'(acc[16]);
          pay_item.item_kind    = pcv_pkg::KIND_PAYLOAD;
          pay_item.payload_byte = trail_bytes[0];
          has_pay = 1'b1;
        end
        trail_bytes[0] = trail_bytes[1];
        trail_bytes[1] = d.rx_byte;
      end
    end
    if (seen_bytes <= MAX_BYTES) seen_bytes++;

    if (d.end_of_packet) begin
      n    = seen_bytes;
      kept = (n > MAX_BYTES) ? MAX_BYTES : n;
      if (n < pcv_pkg::MIN_PACKET_BYTES || n > MAX_BYTES) begin
        verdict = pcv_pkg::ST_LEN_BAD;
      end else if (fold_invert(32'(hdr_words[pcv_pkg::HW_COMMAND]) +
                               32'(hdr_words[pcv_pkg::HW_SIZE]) +
                               32'(hdr_words[pcv_pkg::HW_RESULT])) !=
                   hdr_words[pcv_pkg::HW_CHECK]) begin
        verdict = pcv_pkg::ST_HDR_BAD;
      end else if (32'(hdr_words[pcv_pkg::HW_SIZE]) != n) begin
        verdict = pcv_pkg::ST_LEN_BAD;
      end else if (fold_invert(32'(body_total)) != {trail_bytes[1], trail_bytes[0]}) begin
        verdict = pcv_pkg::ST_BODY_BAD;
      end else begin
        verdict = pcv_pkg::ST_OK;
      end
      stat_item.item_kind      = pcv_pkg::KIND_STATUS;
      stat_item.status         = verdict;
      stat_item.command_code   = hdr_words[pcv_pkg::HW_COMMAND];
      stat_item.result_code    = hdr_words[pcv_pkg::HW_RESULT];
      stat_item.payload_length = (n >= pcv_pkg::MIN_PACKET_BYTES) ?
                                 8'(kept - pcv_pkg::MIN_PACKET_BYTES) : 8'd0;
      has_stat = 1'b1;
      clear_tracker();
    end

    if (has_stat) begin
      stat_item.is_last = 1'b1;
    end else if (has_pay) begin
      pay_item.is_last = 1'b1;
    end
    if (has_pay) due_results.push_back(pay_item);
    if (has_stat) due_results.push_back(stat_item);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Sample on the falling edge: the request completes at the next rising edge.
  always @(negedge clk) begin : result_check
    pcv_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result 0x%0h with nothing pending", out_data);
        error_count++;
      end else begin
        want = due_results.pop_front();
        check_field("item_kind", want.item_kind, out_data.item_kind);
        check_field("payload_byte", want.payload_byte, out_data.payload_byte);
        check_field("status", want.status, out_data.status);
        check_field("command_code", want.command_code, out_data.command_code);
        check_field("result_code", want.result_code, out_data.result_code);
        check_field("payload_length", want.payload_length, out_data.payload_length);
        check_field("is_last", want.is_last, out_data.is_last);
      end
    end
  end

  initial begin : result_sink
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!calm && hold_req) begin
        // Long hold: let the queue fill and back up the input side.
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic offer_byte(input pcv_pkg::in_t d);
    bit took;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_ready;
      if (took) predict_byte(d);
      @(posedge clk);
    end
  endtask

  task automatic send_packet(input pkt_row_t row);
    logic [7:0]   image [$];
    logic [15:0]  hdr_image [4];
    logic [31:0]  acc;
    logic [15:0]  foot_word;
    logic [7:0]   b;
    pcv_pkg::in_t d;
    int unsigned  plen;
    if (row.fill == FILL_NOISE) begin
      repeat (row.nbytes) image.push_back(8'($urandom));
    end else begin
      plen = (row.nbytes > pcv_pkg::MIN_PACKET_BYTES) ?
             row.nbytes - pcv_pkg::MIN_PACKET_BYTES : 0;
      hdr_image[pcv_pkg::HW_COMMAND] = row.cmd;
      hdr_image[pcv_pkg::HW_SIZE]    = 16'(row.nbytes) ^ row.size_flip;
      hdr_image[pcv_pkg::HW_RESULT]  = row.res;
      hdr_image[pcv_pkg::HW_CHECK]   = fold_invert(32'(hdr_image[pcv_pkg::HW_COMMAND]) +
                                                   32'(hdr_image[pcv_pkg::HW_SIZE]) +
                                                   32'(hdr_image[pcv_pkg::HW_RESULT])) ^
                                       row.chk_flip;
      foreach (hdr_image[w]) begin
        image.push_back(hdr_image[w][7:0]);
        image.push_back(hdr_image[w][15:8]);
      end
      acc = '0;
      for (int j = 0; j < plen; j++) begin
        case (row.fill)
          FILL_ZERO: b = 8'h00;
          FILL_ONES: b = 8'hff;
          default:   b = 8'($urandom);
        endcase
        image.push_back(b);
        acc = acc + (j[0] ? {16'h0, b, 8'h00} : 32'(b));
        acc = (acc & 32'h0000_ffff) + (acc >> 16);
      end
      foot_word = fold_invert(acc) ^ row.foot_flip;
      image.push_back(foot_word[7:0]);
      image.push_back(foot_word[15:8]);
    end
    // Short packets stop partway through the header or footer.
    for (int j = 0; j < row.nbytes; j++) begin
      d.rx_byte       = image[j];
      d.end_of_packet = (j == row.nbytes - 1);
      offer_byte(d);
    end
    bytes_sent += row.nbytes;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    pkt_row_t      row;
    pcv_pkg::out_t typed;
    int unsigned   pick;
    int unsigned   pkt_idx;
    clear_tracker();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[r]) begin
      send_packet(DIRECTED_ROWS[r]);
      // Replace the predicted status and payload length with the ones written in the table.
      if (DIRECTED_ROWS[r].st_known) begin
        typed = due_results.pop_back();
        typed.status         = DIRECTED_ROWS[r].st;
        typed.payload_length = DIRECTED_ROWS[r].plen;
        due_results.push_back(typed);
      end
    end
    drain_results();

    bytes_sent = 0;
    pkt_idx    = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent + CALM_BYTES >= RANDOM_BYTES) calm = 1'b1;
      row      = '0;
      row.cmd  = 16'($urandom);
      row.res  = 16'($urandom);
      row.fill = FILL_RANDOM;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 99) == 0) begin
          row.nbytes = 9'($urandom_range(250, 270));
        end else if ($urandom_range(0, 29) == 0) begin
          row.nbytes = 9'($urandom_range(40, 120));
        end else begin
          row.nbytes = 9'($urandom_range(10, 34));
        end
      end else if (pick < 82) begin
        row.nbytes = 9'($urandom_range(10, 34));
        case ($urandom_range(0, 2))
          0: row.chk_flip  = 16'($urandom_range(1, 16'hffff));
          1: row.size_flip = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 3)) :
                                                           16'($urandom_range(1, 16'hffff));
          default: row.foot_flip = 16'($urandom_range(1, 16'hffff));
        endcase
      end else if (pick < 90) begin
        row.nbytes = 9'($urandom_range(1, 9));
        if ($urandom_range(0, 1) == 0) row.chk_flip = 16'($urandom_range(1, 16'hffff));
      end else begin
        row.nbytes = 9'($urandom_range(1, 40));
        row.fill   = FILL_NOISE;
      end
      if (pkt_idx == 1) begin
        hold_req   = 1'b1;
        row        = '0;
        row.nbytes = 9'd40;
        row.cmd    = 16'($urandom);
        row.res    = 16'($urandom);
        row.fill   = FILL_RANDOM;
      end
      if (pkt_idx % 12 == 11) drain_results();
      send_packet(row);
      pkt_idx++;
    end

    calm = 1'b1;
    drain_results();
    if (error_count == 0) begin
      $display("packet_checksum_verifier_test: clean");
    end else begin
      $display("packet_checksum_verifier_test: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/pcv_pkg.sv
src/pcv_front.sv
src/pcv_queue.sv
src/pcv_back.sv
src/packet_checksum_verifier.sv
dv/packet_checksum_verifier_test.sv
